FILE: hw/rtl/spkacc_pkg.sv
`timescale 1ns / 1ps

package spkacc_pkg;

  // Field widths
  localparam int unsigned TimeW    = 32;
  localparam int unsigned SpeedW   = 32;
  localparam int unsigned MagW     = 31;
  localparam int unsigned DenW     = 32;
  // 1000 * |speed delta| stays below 2^42
  localparam int unsigned QuoW     = 42;
  // Two quotient bits per divider step
  localparam int unsigned DivSteps = QuoW / 2;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [9:0]      MsPerSec = 10'd1000;
  localparam logic [MagW-1:0] Max31    = '1;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [9:0]  IntervalReset = 10'd10;
  localparam logic [15:0] MarginReset   = 16'd66;
  localparam logic [15:0] StillReset    = 16'd7;
  localparam logic [19:0] StepReset     = 20'd655;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL    = 2'd0,
    CFG_MARGIN      = 2'd1,
    CFG_STILL_LEVEL = 2'd2,
    CFG_PEAK_STEP   = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PEAK,
    ST_RUN,
    ST_ACC,
    ST_DIV_ACC,
    ST_BEST,
    ST_DIV_INST,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic                     req_type;
    logic [TimeW-1:0]         time_ms;
    logic signed [SpeedW-1:0] speed_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed_now;
    logic [MagW-1:0]          peak_speed;
    logic [MagW-1:0]          best_accel_to_peak;
    logic [TimeW-1:0]         time_to_peak_ms;
    logic signed [SpeedW-1:0] accel_now;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_work_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic div_work_t div_step(div_work_t cur, logic [DenW-1:0] dsr);
    logic [DenW:0] trial;
    div_work_t     res;
    trial   = {cur.rem, cur.quo[QuoW-1]};
    res.quo = {cur.quo[QuoW-2:0], 1'b0};
    if (trial >= {1'b0, dsr}) begin
      res.rem    = DenW'(trial - {1'b0, dsr});
      res.quo[0] = 1'b1;
    end else begin
      res.rem = trial[DenW-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/spkacc_div.sv
`timescale 1ns / 1ps

module spkacc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [spkacc_pkg::QuoW-1:0]      dividend,
  input  logic [spkacc_pkg::DenW-1:0]      divisor,
  output logic [spkacc_pkg::QuoW-1:0]      quotient,
  output spkacc_pkg::div_stat_t            stat
);

  logic [spkacc_pkg::DivCntW-1:0] cnt_r;
  logic                           done_r;
  spkacc_pkg::div_work_t          work_r;
  spkacc_pkg::div_work_t          half;
  spkacc_pkg::div_work_t          work_nxt;
  logic [spkacc_pkg::DenW-1:0]    dsr_r;

  // Two dependent steps per cycle
  always_comb begin
    half     = spkacc_pkg::div_step(work_r, dsr_r);
    work_nxt = spkacc_pkg::div_step(half, dsr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= spkacc_pkg::DivCntW'(spkacc_pkg::DivSteps);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - spkacc_pkg::DivCntW'(1);
        if (cnt_r == spkacc_pkg::DivCntW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r.rem <= '0;
      work_r.quo <= dividend;
      dsr_r      <= divisor;
    end else if (cnt_r != '0) begin
      work_r <= work_nxt;
    end
  end

  assign quotient  = work_r.quo;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

FILE: hw/rtl/speed_peak_accel_monitor_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    in_item   (spkacc_pkg::in_item_t)
// out_     output     out_valid / out_stall  out_item  (spkacc_pkg::out_item_t)
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A clear item is done in ST_IDLE, a sample dropped by the interval check in ST_CHECK;
// an accepted sample then runs ST_PEAK, ST_RUN, ST_ACC, the run-time division when at
// peak with nonzero run time, and the elapsed-time division, both on the shared divider.
// Reset is synchronous, active low; config registers return to their defaults. in_stall
// stays high from a sample's acceptance until it is dropped or its result sits in the
// output register, which holds it while out_stall is high. cfg_ready is always high.

module speed_peak_accel_monitor_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  spkacc_pkg::in_item_t                in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output spkacc_pkg::out_item_t               out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spkacc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [spkacc_pkg::CfgDataW-1:0]     cfg_data
);

  spkacc_pkg::state_t state_r, state_nxt;

  // Configuration
  logic [9:0]  interval_r;
  logic [15:0] margin_r;
  logic [15:0] level_r;
  logic [19:0] step_r;

  // Records that survive between items
  logic [spkacc_pkg::MagW-1:0]  peak_r;
  logic [spkacc_pkg::MagW-1:0]  best_acc_r;
  logic [spkacc_pkg::MagW-1:0]  best_at_r;
  logic [spkacc_pkg::TimeW-1:0] ttp_r;
  logic [spkacc_pkg::TimeW-1:0] still_r;
  logic [spkacc_pkg::TimeW-1:0] last_t_r;
  logic [spkacc_pkg::SpeedW-1:0] last_s_r;

  // Working copy of the current item
  logic [spkacc_pkg::TimeW-1:0]  t_r;
  logic [spkacc_pkg::SpeedW-1:0] s_r;
  logic [spkacc_pkg::MagW-1:0]   mag_r;
  logic [spkacc_pkg::TimeW-1:0]  elapsed_r;
  logic                          dneg_r;
  logic [spkacc_pkg::DenW-1:0]   dmag_r;
  logic                          at_peak_r;
  logic [spkacc_pkg::TimeW-1:0]  run_r;
  logic [spkacc_pkg::MagW-1:0]   acc_r;
  logic [spkacc_pkg::SpeedW-1:0] inst_r;

  logic                  out_valid_r;
  spkacc_pkg::out_item_t out_r;

  // Shared divider
  logic                           div_start;
  logic [spkacc_pkg::QuoW-1:0]    div_dividend;
  logic [spkacc_pkg::DenW-1:0]    div_divisor;
  logic [spkacc_pkg::QuoW-1:0]    div_quo;
  spkacc_pkg::div_stat_t          div_stat;

  logic in_fire;
  logic send_fire;

  // Datapath terms
  logic [spkacc_pkg::TimeW-1:0] elapsed;
  logic                         interval_ok;
  logic [32:0]                  s_ext;
  logic [32:0]                  s_abs;
  logic [spkacc_pkg::MagW-1:0]  mag;
  logic [32:0]                  dlt;
  logic [32:0]                  dlt_abs;
  logic [31:0]                  peak_lim;
  logic [32:0]                  pdiff;
  logic [32:0]                  pdiff_abs;
  logic [31:0]                  step_lim;
  logic                         fresh_best;
  logic [spkacc_pkg::MagW-1:0]  acc_sat;
  logic [spkacc_pkg::SpeedW-1:0] inst_sat;

  assign in_stall  = (state_r != spkacc_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    elapsed     = t_r - last_t_r;
    interval_ok = (elapsed > {22'd0, interval_r});

    // Magnitude, with the most negative speed pinned to 2^31-1
    s_ext = {s_r[31], s_r};
    s_abs = s_ext[32] ? 33'(33'd0 - s_ext) : s_ext;
    mag   = s_abs[31] ? spkacc_pkg::Max31 : s_abs[30:0];

    // Speed change since the last accepted sample, sign and magnitude
    dlt     = s_ext - {last_s_r[31], last_s_r};
    dlt_abs = dlt[32] ? 33'(33'd0 - dlt) : dlt;

    peak_lim = {1'b0, peak_r} + {16'd0, margin_r};

    // Distance of the signed speed from the freshly updated peak
    pdiff     = s_ext - {2'b00, peak_r};
    pdiff_abs = pdiff[32] ? 33'(33'd0 - pdiff) : pdiff;

    step_lim   = {1'b0, best_at_r} + {12'd0, step_r};
    fresh_best = ({1'b0, mag_r} > step_lim);

    acc_sat = (div_quo > {11'd0, spkacc_pkg::Max31}) ? spkacc_pkg::Max31
                                                      : div_quo[30:0];

    // Truncate toward zero on magnitudes, then saturate to the signed range
    if (dneg_r) begin
      if (div_quo > {10'd0, 32'h8000_0000}) begin
        inst_sat = 32'h8000_0000;
      end else begin
        inst_sat = 32'(32'd0 - div_quo[31:0]);
      end
    end else begin
      if (div_quo > {10'd0, 32'h7FFF_FFFF}) begin
        inst_sat = 32'h7FFF_FFFF;
      end else begin
        inst_sat = div_quo[31:0];
      end
    end
  end

  // Sequencer: next state and divider control
  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_dividend = 42'(dmag_r) * 42'(spkacc_pkg::MsPerSec);
    div_divisor  = elapsed_r;
    send_fire    = 1'b0;
    unique case (state_r)
      spkacc_pkg::ST_IDLE: begin
        if (in_fire && !in_item.req_type) begin
          state_nxt = spkacc_pkg::ST_CHECK;
        end
      end
      spkacc_pkg::ST_CHECK: begin
        state_nxt = interval_ok ? spkacc_pkg::ST_PEAK : spkacc_pkg::ST_IDLE;
      end
      spkacc_pkg::ST_PEAK: begin
        state_nxt = spkacc_pkg::ST_RUN;
      end
      spkacc_pkg::ST_RUN: begin
        state_nxt = spkacc_pkg::ST_ACC;
      end
      spkacc_pkg::ST_ACC: begin
        if (!at_peak_r) begin
          // Skip the run division, go straight to the instantaneous one
          div_start = 1'b1;
          state_nxt = spkacc_pkg::ST_DIV_INST;
        end else if (run_r == '0) begin
          state_nxt = spkacc_pkg::ST_BEST;
        end else begin
          div_start    = 1'b1;
          div_dividend = 42'(mag_r) * 42'(spkacc_pkg::MsPerSec);
          div_divisor  = run_r;
          state_nxt    = spkacc_pkg::ST_DIV_ACC;
        end
      end
      spkacc_pkg::ST_DIV_ACC: begin
        if (div_stat.done) begin
          state_nxt = spkacc_pkg::ST_BEST;
        end
      end
      spkacc_pkg::ST_BEST: begin
        div_start = 1'b1;
        state_nxt = spkacc_pkg::ST_DIV_INST;
      end
      spkacc_pkg::ST_DIV_INST: begin
        if (div_stat.done) begin
          state_nxt = spkacc_pkg::ST_SEND;
        end
      end
      spkacc_pkg::ST_SEND: begin
        // Hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          send_fire = 1'b1;
          state_nxt = spkacc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spkacc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spkacc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= spkacc_pkg::IntervalReset;
      margin_r   <= spkacc_pkg::MarginReset;
      level_r    <= spkacc_pkg::StillReset;
      step_r     <= spkacc_pkg::StepReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (spkacc_pkg::cfg_reg_t'(cfg_index))
        spkacc_pkg::CFG_INTERVAL:    interval_r <= cfg_data[9:0];
        spkacc_pkg::CFG_MARGIN:      margin_r   <= cfg_data[15:0];
        spkacc_pkg::CFG_STILL_LEVEL: level_r    <= cfg_data[15:0];
        spkacc_pkg::CFG_PEAK_STEP:   step_r     <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Records and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      best_acc_r  <= '0;
      best_at_r   <= '0;
      ttp_r       <= '0;
      still_r     <= '0;
      last_t_r    <= '0;
      last_s_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the record on a clear item
      if (in_fire && in_item.req_type) begin
        peak_r     <= '0;
        best_acc_r <= '0;
        best_at_r  <= '0;
        ttp_r      <= '0;
      end

      if (state_r == spkacc_pkg::ST_PEAK) begin
        if ({1'b0, mag_r} > peak_lim) begin
          peak_r <= mag_r;
        end
        if (mag_r < {15'd0, level_r}) begin
          still_r <= t_r;
        end
      end

      if (state_r == spkacc_pkg::ST_BEST) begin
        if (fresh_best) begin
          // Enough gain over the best-at speed: restart the record
          best_acc_r <= acc_r;
          ttp_r      <= run_r;
          best_at_r  <= mag_r;
        end else if (acc_r > best_acc_r) begin
          best_acc_r <= acc_r;
          ttp_r      <= run_r;
        end
      end

      if (send_fire) begin
        last_t_r    <= t_r;
        last_s_r    <= s_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      t_r <= in_item.time_ms;
      s_r <= in_item.speed_sample;
    end

    if (state_r == spkacc_pkg::ST_CHECK) begin
      mag_r     <= mag;
      elapsed_r <= elapsed;
      dneg_r    <= dlt[32];
      dmag_r    <= dlt_abs[31:0];
    end

    if (state_r == spkacc_pkg::ST_RUN) begin
      at_peak_r <= (pdiff_abs < {17'd0, margin_r});
      run_r     <= t_r - still_r;
    end

    // Zero elapsed run: any motion counts as the largest acceleration
    if (state_r == spkacc_pkg::ST_ACC) begin
      acc_r <= (mag_r == '0) ? '0 : spkacc_pkg::Max31;
    end

    if (state_r == spkacc_pkg::ST_DIV_ACC && div_stat.done) begin
      acc_r <= acc_sat;
    end

    if (state_r == spkacc_pkg::ST_DIV_INST && div_stat.done) begin
      inst_r <= inst_sat;
    end

    if (send_fire) begin
      out_r.speed_now          <= s_r;
      out_r.peak_speed         <= peak_r;
      out_r.best_accel_to_peak <= best_acc_r;
      out_r.time_to_peak_ms    <= ttp_r;
      out_r.accel_now          <= inst_r;
    end
  end

  spkacc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

`ifndef SYNTH
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == spkacc_pkg::ST_DIV_ACC ||
                       state_r == spkacc_pkg::ST_DIV_INST))
    else $error("divider finished outside a wait state");

  a_clear_records: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_item.req_type |=> peak_r == '0 && best_acc_r == '0 &&
                                    best_at_r == '0 && ttp_r == '0)
    else $error("clear item left records set");

  a_send_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spkacc_pkg::ST_SEND && out_valid_r && out_stall
      |=> state_r == spkacc_pkg::ST_SEND)
    else $error("result overwrote a stalled output");

  a_rise_from_send: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == spkacc_pkg::ST_SEND))
    else $error("output valid without a finished item");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spkacc_pkg::*;

  // Cycles without any handshake before the run is declared hung
  localparam int unsigned IdleLimit    = 2000;
  // Quiet time after the last result before touching registers or ending
  localparam int unsigned SettleCycles = 64;
  // Items per randomized phase, counting only samples that pass the interval test
  localparam int unsigned PhaseItems   = 250;

  localparam longint MagMax = 64'sd2147483647;
  localparam longint MaxS32 = 64'sd2147483647;
  localparam longint MinS32 = -64'sd2147483648;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  speed_peak_accel_monitor_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the register file, updated on each config handshake
  logic [9:0]  interval_ms = IntervalReset;
  logic [15:0] margin_q    = MarginReset;
  logic [15:0] still_q     = StillReset;
  logic [19:0] step_q      = StepReset;

  // Shadow copy of the block's tracking state
  logic [30:0]        peak_q       = '0;
  logic [30:0]        best_acc_q   = '0;
  logic [30:0]        best_speed_q = '0;
  logic [31:0]        ttp_q        = '0;
  logic [31:0]        still_time_q = '0;
  logic [31:0]        last_time_q  = '0;
  logic signed [31:0] last_speed_q = '0;

  in_item_t  pending_items[$];   // items waiting for the driver
  out_item_t expected_results[$]; // predicted results, oldest first

  // Handshake control shared between the stimulus thread and the drivers
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_fire = 1'b0;
  bit          drain_hold = 1'b0;
  int unsigned quiet_cycles = 0;

  // Run statistics
  int n_errors  = 0;
  int n_results = 0;
  int n_dropped = 0;
  int n_clears  = 0;
  int n_at_peak = 0;

  // Stimulus-side mirror of the last accepted time, used to count real samples
  logic [31:0] gen_t    = '0;
  logic [31:0] gen_last = '0;
  int          n_gen    = 0;

  // Advance the tracking state by one item; return 1 with the result when one is due.
  function automatic bit predict_result(input in_item_t it, output out_item_t res);
    logic [31:0] elapsed;
    logic [31:0] run;
    longint      s;
    longint      mag;
    longint      diff;
    longint      acc;
    longint      inst;
    res = '0;
    // Clear wipes the peak records only; time and speed fields are don't-care
    if (it.req_type) begin
      peak_q       = '0;
      best_acc_q   = '0;
      best_speed_q = '0;
      ttp_q        = '0;
      n_clears++;
      return 1'b0;
    end
    // Drop samples that come too soon; elapsed wraps modulo 2^32
    elapsed = it.time_ms - last_time_q;
    if (elapsed <= 32'(interval_ms)) begin
      n_dropped++;
      return 1'b0;
    end
    s   = longint'($signed(it.speed_sample));
    mag = (s < 0) ? -s : s;
    if (mag > MagMax) mag = MagMax;   // most negative speed clips to 2^31-1
    if (mag > longint'(margin_q) + longint'(peak_q)) peak_q = mag[30:0];
    if (mag < longint'(still_q)) still_time_q = it.time_ms;
    // At peak: signed speed within the margin of the recorded peak
    diff = s - longint'(peak_q);
    if (diff < 0) diff = -diff;
    if (diff < longint'(margin_q)) begin
      n_at_peak++;
      run = it.time_ms - still_time_q;
      // Zero run time saturates unless the speed is zero as well
      if (run == 0) acc = (mag == 0) ? 0 : MagMax;
      else acc = (1000 * mag) / longint'(run);
      if (acc > MagMax) acc = MagMax;
      if (mag > longint'(best_speed_q) + longint'(step_q)) begin
        // Clearly faster than the best-at speed: restart the record
        best_acc_q   = acc[30:0];
        ttp_q        = run;
        best_speed_q = mag[30:0];
      end else if (acc > longint'(best_acc_q)) begin
        best_acc_q = acc[30:0];
        ttp_q      = run;
      end
    end
    // Instantaneous acceleration, truncated toward zero and clipped to 32 bits
    inst = (1000 * (s - longint'(last_speed_q))) / longint'(elapsed);
    if (inst > MaxS32) inst = MaxS32;
    if (inst < MinS32) inst = MinS32;
    res.speed_now          = it.speed_sample;
    res.peak_speed         = peak_q;
    res.best_accel_to_peak = best_acc_q;
    res.time_to_peak_ms    = ttp_q;
    res.accel_now          = inst[31:0];
    last_speed_q = it.speed_sample;
    last_time_q  = it.time_ms;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Sample both channels at the rising edge: predict on input acceptance,
  // compare on result acceptance, and run the hang watchdog.
  always @(posedge clk) begin : check_blk
    out_item_t want;
    out_item_t next_res;
    bit        out_fire;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (in_fire && predict_result(in_item, next_res)) expected_results.push_back(next_res);
    if (out_fire) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: speed_now %0h", out_item.speed_now);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("speed_now", want.speed_now, out_item.speed_now);
        check_field("peak_speed", want.peak_speed, out_item.peak_speed);
        check_field("best_accel_to_peak", want.best_accel_to_peak,
                    out_item.best_accel_to_peak);
        check_field("time_to_peak_ms", want.time_to_peak_ms, out_item.time_to_peak_ms);
        check_field("accel_now", want.accel_now, out_item.accel_now);
        n_results++;
      end
    end
    if (!rst_n || in_fire || out_fire || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Input driver: advance at the falling edge, hold the item while stalled.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      // Release an earlier pause once every predicted result has come back
      if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;
      if (!drain_hold && pending_items.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item  <= pending_items.pop_front();
        // Now and then pause after this item until the block has drained
        if ($urandom_range(199) == 0) drain_hold = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall at the phase's rate, never during reset
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INTERVAL:    interval_ms = val[9:0];
      CFG_MARGIN:      margin_q    = val[15:0];
      CFG_STILL_LEVEL: still_q     = val[15:0];
      CFG_PEAK_STEP:   step_q      = val[19:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [9:0] intv, input logic [15:0] marg,
                           input logic [15:0] still, input logic [19:0] step);
    write_reg(CFG_INTERVAL, CfgDataW'(intv));
    write_reg(CFG_MARGIN, CfgDataW'(marg));
    write_reg(CFG_STILL_LEVEL, CfgDataW'(still));
    write_reg(CFG_PEAK_STEP, step);
  endtask

  // Wait until every queued item is in and every predicted result is out,
  // then give dropped samples and clears time to finish inside the block.
  task automatic drain_block();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic add_sample(input logic [31:0] t, input logic [31:0] s);
    in_item_t it;
    it.req_type     = 1'b0;
    it.time_ms      = t;
    it.speed_sample = s;
    pending_items.push_back(it);
    if (t - gen_last > 32'(interval_ms)) begin
      gen_last = t;
      n_gen++;
    end
  endtask

  task automatic add_clear();
    in_item_t it;
    it.req_type     = 1'b1;
    it.time_ms      = $urandom();
    it.speed_sample = $urandom();
    pending_items.push_back(it);
  endtask

  // Next timestamp: mostly just past the interval, sometimes too early,
  // sometimes a jump anywhere in the 32-bit range.
  function automatic logic [31:0] next_time();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) gen_t += $urandom_range(int'(interval_ms));
    else if (r < 8) gen_t = $urandom();
    else gen_t += int'(interval_ms) + $urandom_range(1, 40);
    return gen_t;
  endfunction

  // One drive: stand, ramp up to a top speed, hover at it, then slow down
  task automatic add_drive();
    longint      top;
    longint      v;
    longint      floor_v;
    int unsigned steps;
    int unsigned n;
    if ($urandom_range(7) == 0) top = longint'($urandom_range(32'h7FFF_FFFF));
    else top = longint'($urandom_range(40 * 65536));
    n = $urandom_range(1, 3);
    repeat (n) begin
      v = longint'($urandom_range(int'(still_q)));
      if ($urandom_range(1) != 0) v = -v;
      add_sample(next_time(), v[31:0]);
    end
    steps = $urandom_range(2, 8);
    for (int i = 1; i <= steps; i++) begin
      v = top * longint'(i) / longint'(steps);
      add_sample(next_time(), v[31:0]);
    end
    n = $urandom_range(0, 3);
    repeat (n) begin
      v = top + longint'($urandom_range(2 * int'(margin_q))) - longint'(margin_q);
      if (v > MaxS32) v = MaxS32;
      add_sample(next_time(), v[31:0]);
    end
    // Sometimes end up reversing
    floor_v = ($urandom_range(3) == 0) ? -longint'($urandom_range(5 * 65536)) : 0;
    steps = $urandom_range(1, 4);
    for (int i = 1; i <= steps; i++) begin
      v = top + (floor_v - top) * longint'(i) / longint'(steps);
      add_sample(next_time(), v[31:0]);
    end
  endtask

  task automatic add_noise();
    logic [31:0] s;
    case ($urandom_range(3))
      0:       s = 32'h8000_0000;
      1:       s = 32'h7FFF_FFFF;
      default: s = $urandom();
    endcase
    add_sample(next_time(), s);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int          target;
    // Hold reset low, then release it with a nonblocking write so the
    // falling-edge drivers all see the same value
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset register values
    add_sample(32'd100, 32'd0);              // zero speed at zero run time
    add_sample(32'd200, 32'd3);              // standing but nonzero: saturated accel
    add_clear();
    add_sample(32'd205, 32'd1000);           // too early, dropped
    add_sample(32'd210, 32'd327680);         // exactly on the interval, dropped
    add_sample(32'd211, 32'd327680);         // first sample past the interval
    add_sample(32'd300, 32'h7FFF_FFFF);      // top speed, accel clips high
    add_sample(32'd400, 32'h8000_0000);      // most negative, accel clips low
    add_sample(32'hFFFF_FFF0, 32'd0);
    add_sample(32'h0000_0010, 32'd100000);   // time wraps
    add_sample(32'h0000_001B, 32'd100030);   // hover within the margin
    add_sample(32'h0000_0030, 32'hFFFF_FFFF); // tiny reverse speed, standing
    add_sample(32'h0000_0060, 32'd200000);   // big gain, but far off the peak: best record unchanged
    add_sample(32'h0000_0090, 32'd200010);   // still off peak, no update
    add_clear();
    add_sample(32'h0000_0100, 32'h8000_0001);
    add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_sample(32'hFFFF_FFFF, 32'h5555_5555);
    add_sample(32'hAAAA_AAAA, 32'hAAAA_AAAA);
    gen_t = 32'hAAAA_AAAA;
    drain_block();

    // Randomized phases, each with its own register set and idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_all(10'd0, 16'hFFFF, 16'hFFFF, 20'd0);
        1: write_all(10'd1000, 16'd0, 16'd0, 20'd655360);
        2: write_all(10'($urandom_range(1, 50)), 16'($urandom_range(1, 2000)),
                     16'($urandom_range(2000)), 20'($urandom_range(655360)));
        default: write_all(IntervalReset, MarginReset, StillReset, StepReset);
      endcase
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      target = n_gen + PhaseItems;
      while (n_gen < target) begin
        pick = $urandom_range(99);
        if (pick < 5) add_clear();
        else if (pick < 20) repeat ($urandom_range(1, 4)) add_noise();
        else add_drive();
      end
      drain_block();
    end

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      n_errors++;
    end
    $display("run covered %0d checked results, %0d dropped samples, %0d clears,",
             n_results, n_dropped, n_clears);
    $display("  %0d at-peak evaluations, over five register sets and four idle patterns",
             n_at_peak);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/spkacc_pkg.sv
hw/rtl/spkacc_div.sv
hw/rtl/speed_peak_accel_monitor_unit.sv
verif/tb_top.sv
